/* rtl/core/gpps_pkg.sv */
package gpps_pkg;

    localparam int VAL_W = 16;
    localparam int OUT_W = 15;
    localparam int DIV_W = 9;
    localparam int SQ_W  = 2 * DIV_W - 1;
    localparam int CNT_W = $clog2(VAL_W);

    localparam logic [VAL_W-1:0] FOUR_VAL  = VAL_W'(4);
    localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(3);
    localparam logic [SQ_W-1:0]  FIRST_SQ  = SQ_W'(9);
    localparam logic [OUT_W-1:0] TWO_OUT   = OUT_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CAND,
        S_TEST,
        S_DIV,
        S_CHK,
        S_OUT_PAIR,
        S_OUT_NONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic start_p;
        logic start_q;
        logic div_init;
        logic div_step;
        logic next_d;
        logic next_p;
        logic out_pair;
        logic out_none;
    } cmd_t;

    typedef struct packed {
        logic trivial;
        logic p_over;
        logic dsq_gt_n;
        logic is_q;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/gpps_ctrl.sv */
module gpps_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  gpps_pkg::sts_t sts,
    output gpps_pkg::cmd_t cmd
);
    import gpps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                state_next = sts.trivial ? S_OUT_NONE : S_CAND;
            end
            S_CAND:
            begin
                if (sts.p_over)
                begin
                    state_next = S_OUT_NONE;
                end
                else
                begin
                    cmd.start_p = 1'b1;
                    state_next  = S_TEST;
                end
            end
            S_TEST:
            begin
                if (sts.dsq_gt_n)
                begin
                    if (sts.is_q)
                    begin
                        state_next = S_OUT_PAIR;
                    end
                    else
                    begin
                        cmd.start_q = 1'b1;
                    end
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.rem_zero)
                begin
                    cmd.next_p = 1'b1;
                    state_next = S_CAND;
                end
                else
                begin
                    cmd.next_d = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_OUT_PAIR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_pair = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_OUT_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_none = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

/* rtl/core/gpps_dp.sv */
module gpps_dp #(
    parameter int MAX_VALUE = 32768
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [gpps_pkg::VAL_W-1:0]   even_value,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [gpps_pkg::OUT_W-1:0]   prime_low,
    output logic [gpps_pkg::OUT_W-1:0]   prime_high,
    input  gpps_pkg::cmd_t               cmd,
    output gpps_pkg::sts_t               sts
);
    import gpps_pkg::*;

    logic [VAL_W-1:0] v_reg;
    logic [VAL_W-1:0] p_reg;
    logic [VAL_W-1:0] n_reg;
    logic [DIV_W-1:0] d_reg;
    logic [SQ_W-1:0]  dsq_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [VAL_W-1:0] shift_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             is_q_reg;
    logic [OUT_W-1:0] lo_reg;
    logic [OUT_W-1:0] hi_reg;
    logic             out_valid_reg;

    logic [VAL_W-1:0] q_val;
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] rem_next;
    logic [SQ_W-1:0]  dsq_next;

    assign q_val = v_reg - p_reg;
    assign trial = {rem_reg, shift_reg[VAL_W-1]};

    always_comb
    begin
        if (trial >= {1'b0, d_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, d_reg});
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    // (d+2)^2 = d^2 + 4d + 4
    assign dsq_next = dsq_reg + SQ_W'({d_reg, 2'b00}) + SQ_W'(4);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            v_reg <= even_value;
            p_reg <= VAL_W'(3);
        end
        if (cmd.next_p)
        begin
            p_reg <= p_reg + VAL_W'(2);
        end
        if (cmd.start_p || cmd.start_q)
        begin
            n_reg   <= cmd.start_q ? q_val : p_reg;
            d_reg   <= FIRST_DIV;
            dsq_reg <= FIRST_SQ;
        end
        if (cmd.next_d)
        begin
            d_reg   <= d_reg + DIV_W'(2);
            dsq_reg <= dsq_next;
        end
        if (cmd.div_init)
        begin
            rem_reg   <= '0;
            shift_reg <= n_reg;
            cnt_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[VAL_W-2:0], 1'b0};
            cnt_reg   <= cnt_reg + CNT_W'(1);
        end
        if (cmd.out_pair)
        begin
            lo_reg <= p_reg[OUT_W-1:0];
            hi_reg <= q_val[OUT_W-1:0];
        end
        if (cmd.out_none)
        begin
            lo_reg <= TWO_OUT;
            hi_reg <= TWO_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_q_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_p)
            begin
                is_q_reg <= 1'b0;
            end
            else if (cmd.start_q)
            begin
                is_q_reg <= 1'b1;
            end
            if (cmd.out_pair || cmd.out_none)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.trivial  = (v_reg == FOUR_VAL) || v_reg[0] || (32'(v_reg) > 32'(MAX_VALUE));
    assign sts.p_over   = (p_reg > {1'b0, v_reg[VAL_W-1:1]});
    assign sts.dsq_gt_n = (dsq_reg > SQ_W'(n_reg));
    assign sts.is_q     = is_q_reg;
    assign sts.div_last = (cnt_reg == CNT_W'(VAL_W - 1));
    assign sts.rem_zero = (rem_reg == '0);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign prime_low  = lo_reg;
    assign prime_high = hi_reg;

endmodule

/* rtl/core/goldbach_prime_pair_search.sv */
// goldbach prime pair search
// input channel: even_value with in_valid / in_stall; one item is taken when
// in_valid is high and in_stall is low, and in_stall stays high until the
// search for that item has finished and its result is in the output register
// output channel: prime_low / prime_high with out_valid / out_stall; one
// result item per input item, smallest low prime first, 2 + 2 for zero, two,
// four, odd values and values above MAX_VALUE
// search steps: an item that needs no search goes from the start check
// straight to its result, and a value below four first passes the candidate
// check; otherwise the item is loaded, each tried candidate is checked and,
// once it proves prime, its partner is set up for test; each trial division
// is a divisor check, a 16-step bit-serial remainder and a remainder check,
// and the result is closed out last; proving a prime near 32768 alone takes
// up to 90 trial divisions
// one item is in the search at a time; the next item can be taken in the cycle
// after the result has moved to the output register, which frees the search
// while the result waits
// a stalled result holds its value; a finished search waits for the output
// register to free before writing it
// reset clears the controller and out_valid; no result is pending after reset
module goldbach_prime_pair_search #(
    parameter int MAX_VALUE = 32768
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [gpps_pkg::VAL_W-1:0]   even_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [gpps_pkg::OUT_W-1:0]   prime_low,
    output logic [gpps_pkg::OUT_W-1:0]   prime_high
);
    import gpps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gpps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gpps_dp #(
        .MAX_VALUE (MAX_VALUE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .even_value (even_value),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .prime_low  (prime_low),
        .prime_high (prime_high),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

/* sim/goldbach_prime_pair_search_tb.sv */
module goldbach_prime_pair_search_tb;

    import gpps_pkg::*;

    localparam int MAX_VAL = 32768;
    localparam int N_RANDOM = 120;
    localparam int N_DIRECTED = 21;

    typedef struct packed {
        logic [OUT_W-1:0] lo;
        logic [OUT_W-1:0] hi;
    } pair_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             fixed;
        logic [OUT_W-1:0] lo;
        logic [OUT_W-1:0] hi;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [VAL_W-1:0] even_value;
    logic             out_valid;
    logic             out_stall;
    logic [OUT_W-1:0] prime_low;
    logic [OUT_W-1:0] prime_high;

    pair_t pending_pairs[$];
    int    mismatch_count;
    bit    sender_quiet;
    bit    receiver_quiet;

    // value, typed-in flag, prime_low, prime_high
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{16'd0,     1'b1, 15'd2, 15'd2},
        '{16'd1,     1'b1, 15'd2, 15'd2},
        '{16'd2,     1'b1, 15'd2, 15'd2},
        '{16'd3,     1'b1, 15'd2, 15'd2},
        '{16'd4,     1'b1, 15'd2, 15'd2},
        '{16'd5,     1'b1, 15'd2, 15'd2},
        '{16'd6,     1'b1, 15'd3, 15'd3},
        '{16'd7,     1'b1, 15'd2, 15'd2},
        '{16'd8,     1'b1, 15'd3, 15'd5},
        '{16'd10,    1'b0, 15'd0, 15'd0},
        '{16'd12,    1'b0, 15'd0, 15'd0},
        '{16'd100,   1'b0, 15'd0, 15'd0},
        '{16'd1023,  1'b0, 15'd0, 15'd0},
        '{16'd16384, 1'b0, 15'd0, 15'd0},
        '{16'h5554,  1'b0, 15'd0, 15'd0},
        '{16'd32766, 1'b0, 15'd0, 15'd0},
        '{16'd32768, 1'b0, 15'd0, 15'd0},
        '{16'd32769, 1'b1, 15'd2, 15'd2},
        '{16'hAAAA,  1'b1, 15'd2, 15'd2},
        '{16'd65534, 1'b1, 15'd2, 15'd2},
        '{16'd65535, 1'b1, 15'd2, 15'd2}
    };

    goldbach_prime_pair_search #(
        .MAX_VALUE(MAX_VAL)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .even_value(even_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .prime_low(prime_low),
        .prime_high(prime_high)
    );

    always #10 clk = ~clk;

    function automatic bit is_prime_by_division(input int n);
        if (n <= 1)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (n % 2 == 0)
            return 1'b0;
        for (int d = 3; d * d <= n; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // smallest odd prime p with value - p also prime, else 2 + 2
    function automatic pair_t goldbach_split(input logic [VAL_W-1:0] value);
        int    v;
        pair_t r;
        v = int'(value);
        r.lo = OUT_W'(2);
        r.hi = OUT_W'(2);
        if (v != 4 && v <= MAX_VAL)
        begin
            for (int p = 3; p <= v / 2; p += 2)
            begin
                if (is_prime_by_division(p) && is_prime_by_division(v - p))
                begin
                    r.lo = OUT_W'(p);
                    r.hi = OUT_W'(v - p);
                    break;
                end
            end
        end
        return r;
    endfunction

    function automatic int idle_cycles(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 11));
    endfunction

    task automatic send_value(input logic [VAL_W-1:0] value, input bit fixed,
                              input pair_t typed);
        int gap;
        gap = idle_cycles(sender_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            even_value <= VAL_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        even_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pairs.push_back(fixed ? typed : goldbach_split(value));
    endtask

    task automatic drain_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] random_value;
        case ($urandom_range(0, 15))
            11:      return VAL_W'($urandom_range(2, 32) * 2);
            12:      return VAL_W'($urandom_range(0, 255) * 2 + 1);
            13:      return VAL_W'($urandom_range(MAX_VAL + 1, 65535));
            14:      return VAL_W'($urandom_range(0, 5));
            default: return VAL_W'($urandom_range(3, MAX_VAL / 2) * 2);
        endcase
    endfunction

    always @(posedge clk)
    begin : result_check
        pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pairs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t unexpected item: prime_low %0d prime_high %0d",
                         $time, prime_low, prime_high);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (prime_low !== want.lo)
                begin
                    mismatch_count++;
                    $display("%0t prime_low expected %0d actual %0d",
                             $time, want.lo, prime_low);
                end
                if (prime_high !== want.hi)
                begin
                    mismatch_count++;
                    $display("%0t prime_high expected %0d actual %0d",
                             $time, want.hi, prime_high);
                end
            end
        end
    end

    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                receiver_quiet = !receiver_quiet;
            n = idle_cycles(receiver_quiet);
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #1_000_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        pair_t typed;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        even_value = '0;
        out_stall = 1'b0;
        mismatch_count = 0;
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            typed.lo = directed_rows[i].lo;
            typed.hi = directed_rows[i].hi;
            send_value(directed_rows[i].value, directed_rows[i].fixed, typed);
        end

        // let the pipeline empty before the random part
        drain_results();

        typed = '0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 20 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            if (i == N_RANDOM / 2)
                drain_results();
            send_value(random_value(), 1'b0, typed);
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/gpps_pkg.sv
rtl/core/gpps_ctrl.sv
rtl/core/gpps_dp.sv
rtl/core/goldbach_prime_pair_search.sv
sim/goldbach_prime_pair_search_tb.sv
